### rtl/msf_pkg.sv
// msf_pkg: shared constants, types and helpers of the message slot fifo
// used by every file of the block, no dependencies

package msf_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_BYTES = 32;
  localparam int DEPTH      = SLOT_COUNT * SLOT_BYTES;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BYTE_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int LEN_W  = $clog2(SLOT_BYTES + 1);

  localparam int CAP_CFG_W   = 5;
  localparam int BYTES_CFG_W = 6;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CAPCMP_W    = (CNT_W > CAP_CFG_W) ? CNT_W : CAP_CFG_W;
  localparam int LENCMP_W    = (LEN_W > BYTES_CFG_W) ? LEN_W : BYTES_CFG_W;
  localparam int LENGTH_W    = 16;

  typedef logic [SLOT_W-1:0]      slot_idx_t;
  typedef logic [BYTE_W-1:0]      byte_idx_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [LENGTH_W-1:0]    length_t;
  typedef logic [CAPCMP_W-1:0]    capcmp_t;
  typedef logic [LENCMP_W-1:0]    lencmp_t;
  typedef logic [CAP_CFG_W-1:0]   cap_cfg_t;
  typedef logic [BYTES_CFG_W-1:0] bytes_cfg_t;

  localparam cap_cfg_t   CAP_RESET   = 5'd16;
  localparam bytes_cfg_t BYTES_RESET = 6'd32;
  localparam length_t    LENGTH_MAX  = 16'hFFFF;
  localparam logic [7:0] EMPTY_CHAR  = 8'h30;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES    = 1'b1;

  localparam logic KIND_FEEDBACK = 1'b0;
  localparam logic KIND_FRONT    = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_READ = 2'd1,
    CMD_POP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_READ
  } state_e;

  typedef struct packed {
    logic       result_kind;
    logic       was_full;
    logic       accepted;
    length_t    excess_bytes;
    logic [7:0] front_byte;
    logic       queue_empty;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
    logic       re;
    addr_t      raddr;
  } ram_req_t;

  typedef struct packed {
    cnt_t stored_count;
    logic busy;
  } sts_t;

  function automatic addr_t slot_addr(input slot_idx_t slot, input byte_idx_t idx);
    slot_addr = addr_t'(slot) * addr_t'(SLOT_BYTES) + addr_t'(idx);
  endfunction

endpackage

### rtl/msf_ifs.sv
// msf_ifs: valid/ready channel interfaces for items in and results out
// depends on msf_pkg

interface msf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] message_byte;
  logic       end_of_message;

  modport source (output valid, command, message_byte, end_of_message, input ready);
  modport sink (input valid, command, message_byte, end_of_message, output ready);
endinterface

interface msf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic                          was_full;
  logic                          accepted;
  logic [msf_pkg::LENGTH_W-1:0]  excess_bytes;
  logic [7:0]                    front_byte;
  logic                          queue_empty;
  logic                          last_of_run;

  modport source (output valid, result_kind, was_full, accepted, excess_bytes, front_byte,
                  queue_empty, last_of_run, input ready);
  modport sink (input valid, result_kind, was_full, accepted, excess_bytes, front_byte,
                queue_empty, last_of_run, output ready);
endinterface

### rtl/msf_slot_ram.sv
// msf_slot_ram: slot byte store, one write and one registered read port
// depends on msf_pkg

module msf_slot_ram (
  input  logic              clk_i,
  input  msf_pkg::ram_req_t req_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [msf_pkg::DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/msf_ctrl.sv
// msf_ctrl: command sequencer, ring pointers, zero fill and read walk
// depends on msf_pkg, msf_ifs and drives msf_slot_ram

module msf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  msf_in_if.sink            in_i,
  msf_out_if.source         out_o,
  input  msf_pkg::cnt_t     cap_i,
  input  msf_pkg::len_t     len_i,
  output msf_pkg::ram_req_t ram_o,
  input  logic [7:0]        ram_rdata_i,
  output msf_pkg::sts_t     sts_o
);

  msf_pkg::state_e    state_q, state_d;
  msf_pkg::slot_idx_t head_q, head_d, tail_q, tail_d, pad_slot_q, pad_slot_d;
  msf_pkg::cnt_t      count_q, count_d;
  msf_pkg::length_t   inlen_q, inlen_d;
  logic               rejected_q, rejected_d, open_q, open_d;
  msf_pkg::byte_idx_t idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  msf_pkg::res_t      out_q, out_d;

  logic               out_free, in_fire, rej, store_en, rd_last, pad_done;
  msf_pkg::length_t   len_cur, len_new, len16, excess;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == msf_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;

  // fullness is fixed at the first byte of a message
  assign rej      = open_q ? rejected_q : (count_q >= cap_i);
  assign len_cur  = open_q ? inlen_q : '0;
  assign len_new  = (len_cur == msf_pkg::LENGTH_MAX) ? len_cur : len_cur + 1'b1;
  assign len16    = msf_pkg::length_t'(len_i);
  assign store_en = !rej && (len_cur < len16);
  assign excess   = (len_new > len16) ? len_new - len16 : '0;
  assign rd_last  = (msf_pkg::len_t'(idx_q) == len_i - msf_pkg::len_t'(1));
  assign pad_done = (idx_q == msf_pkg::byte_idx_t'(msf_pkg::SLOT_BYTES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      msf_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_i.command)
            msf_pkg::CMD_PUSH: begin
              if (in_i.end_of_message && !rej &&
                  (len_new < msf_pkg::length_t'(msf_pkg::SLOT_BYTES))) begin
                state_d = msf_pkg::ST_PAD;
              end
            end
            msf_pkg::CMD_READ: begin
              if (count_q != '0) begin
                state_d = msf_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      msf_pkg::ST_PAD: begin
        if (pad_done) begin
          state_d = msf_pkg::ST_IDLE;
        end
      end
      msf_pkg::ST_READ: begin
        if (out_free && rd_last) begin
          state_d = msf_pkg::ST_IDLE;
        end
      end
      default: state_d = msf_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory access
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    pad_slot_d  = pad_slot_q;
    count_d     = count_q;
    inlen_d     = inlen_q;
    rejected_d  = rejected_q;
    open_d      = open_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    ram_o       = '0;

    case (state_q)
      msf_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_i.command)
            msf_pkg::CMD_PUSH: begin
              ram_o.we    = store_en;
              ram_o.waddr = msf_pkg::slot_addr(tail_q, len_cur[msf_pkg::BYTE_W-1:0]);
              ram_o.wdata = in_i.message_byte;
              open_d      = !in_i.end_of_message;
              inlen_d     = len_new;
              rejected_d  = rej;
              if (in_i.end_of_message) begin
                out_valid_d = 1'b1;
                out_d       = '{result_kind: msf_pkg::KIND_FEEDBACK, was_full: rej,
                                accepted: !rej, excess_bytes: rej ? '0 : excess,
                                front_byte: 8'h00, queue_empty: 1'b0, last_of_run: 1'b1};
                if (!rej) begin
                  pad_slot_d = tail_q;
                  idx_d      = len_new[msf_pkg::BYTE_W-1:0];
                  tail_d     = (tail_q == msf_pkg::slot_idx_t'(msf_pkg::SLOT_COUNT - 1)) ?
                               '0 : tail_q + 1'b1;
                  count_d    = count_q + 1'b1;
                end
              end
            end
            msf_pkg::CMD_READ: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_d       = '{result_kind: msf_pkg::KIND_FRONT, was_full: 1'b0,
                                accepted: 1'b0, excess_bytes: '0,
                                front_byte: msf_pkg::EMPTY_CHAR, queue_empty: 1'b1,
                                last_of_run: 1'b1};
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = msf_pkg::slot_addr(head_q, '0);
                idx_d       = '0;
              end
            end
            msf_pkg::CMD_POP: begin
              if (count_q != '0) begin
                head_d  = (head_q == msf_pkg::slot_idx_t'(msf_pkg::SLOT_COUNT - 1)) ?
                          '0 : head_q + 1'b1;
                count_d = count_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      msf_pkg::ST_PAD: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = msf_pkg::slot_addr(pad_slot_q, idx_q);
        ram_o.wdata = 8'h00;
        if (!pad_done) begin
          idx_d = idx_q + 1'b1;
        end
      end
      msf_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{result_kind: msf_pkg::KIND_FRONT, was_full: 1'b0,
                          accepted: 1'b0, excess_bytes: '0, front_byte: ram_rdata_i,
                          queue_empty: 1'b0, last_of_run: rd_last};
          if (!rd_last) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = msf_pkg::slot_addr(head_q, idx_q + 1'b1);
            idx_d       = idx_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msf_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      pad_slot_q  <= '0;
      count_q     <= '0;
      inlen_q     <= '0;
      rejected_q  <= 1'b0;
      open_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pad_slot_q  <= pad_slot_d;
      count_q     <= count_d;
      inlen_q     <= inlen_d;
      rejected_q  <= rejected_d;
      open_q      <= open_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_q.result_kind;
  assign out_o.was_full     = out_q.was_full;
  assign out_o.accepted     = out_q.accepted;
  assign out_o.excess_bytes = out_q.excess_bytes;
  assign out_o.front_byte   = out_q.front_byte;
  assign out_o.queue_empty  = out_q.queue_empty;
  assign out_o.last_of_run  = out_q.last_of_run;

  assign sts_o.stored_count = count_q;
  assign sts_o.busy         = (state_q != msf_pkg::ST_IDLE);

endmodule

### rtl/message_slot_fifo.sv
// message_slot_fifo: top level, configuration registers, sequencer and slot store
// depends on msf_pkg, msf_ifs, msf_slot_ram, msf_ctrl
//
// Usage: items arrive on in_i (command, message_byte, end_of_message) and results
// leave on out_o, both valid/ready; a transfer happens when valid and ready are high.
// A push streams one byte per transfer; the end-marked byte yields one feedback
// result (was_full, accepted, excess_bytes). A read yields the head slot's bytes, up to
// the configured length, or one empty marker. A pop removes the head and yields nothing.
// An accepted end-of-message byte is followed by a zero fill of the rest of its slot
// through the single memory write port, none when the message fills the slot. A read
// of a stored slot first waits on the registered memory read, then yields one byte
// per cycle while the receiver takes each result, up to the configured length.
// Results pass through one output register; a stalled receiver holds it and the
// block takes no new item until that result is taken.
// Reset clears pointers, counts and the output valid; the slot store is not
// cleared and needs no sweep, so the block is ready right after reset.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i must go in only while idle; the block does not enforce this.

module message_slot_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  msf_in_if.sink                           in_i,
  msf_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [msf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  msf_pkg::cap_cfg_t   cap_cfg_q;
  msf_pkg::bytes_cfg_t bytes_cfg_q;
  msf_pkg::capcmp_t    cap_x;
  msf_pkg::lencmp_t    len_x;
  msf_pkg::cnt_t       cap_eff;
  msf_pkg::len_t       len_eff;
  msf_pkg::ram_req_t   ram_req;
  logic [7:0]          ram_rdata;
  msf_pkg::sts_t       sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q   <= msf_pkg::CAP_RESET;
      bytes_cfg_q <= msf_pkg::BYTES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msf_pkg::CFG_CAPACITY: cap_cfg_q   <= cfg_data_i[msf_pkg::CAP_CFG_W-1:0];
        msf_pkg::CFG_BYTES:    bytes_cfg_q <= cfg_data_i[msf_pkg::BYTES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their usable ranges
  always_comb begin
    cap_x = msf_pkg::capcmp_t'(cap_cfg_q);
    if (cap_x == '0) begin
      cap_x = msf_pkg::capcmp_t'(1);
    end else if (cap_x > msf_pkg::capcmp_t'(msf_pkg::SLOT_COUNT)) begin
      cap_x = msf_pkg::capcmp_t'(msf_pkg::SLOT_COUNT);
    end
    len_x = msf_pkg::lencmp_t'(bytes_cfg_q);
    if (len_x == '0) begin
      len_x = msf_pkg::lencmp_t'(1);
    end else if (len_x > msf_pkg::lencmp_t'(msf_pkg::SLOT_BYTES)) begin
      len_x = msf_pkg::lencmp_t'(msf_pkg::SLOT_BYTES);
    end
  end

  assign cap_eff = msf_pkg::cnt_t'(cap_x);
  assign len_eff = msf_pkg::len_t'(len_x);

  msf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cap_i       (cap_eff),
    .len_i       (len_eff),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata),
    .sts_o       (sts)
  );

  msf_slot_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!out_o.valid || out_o.ready))
    else $error("input transfer while a result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.command == msf_pkg::CMD_READ &&
     sts.stored_count == '0) |=> (out_o.valid && out_o.queue_empty && out_o.last_of_run))
    else $error("read of empty queue gave no empty marker");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.command == msf_pkg::CMD_POP &&
     sts.stored_count != '0) |=> (sts.stored_count == $past(sts.stored_count) - 1'b1))
    else $error("pop did not lower the stored count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> !in_i.ready)
    else $error("input ready during fill or read walk");

endmodule
